@@ rtl/ils_pkg.sv @@
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types, codes and sizes for the indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

    // store depth and derived widths
    localparam int CAPACITY = 64;
    localparam int IDX_W    = 7;
    localparam int LEN_W    = 7;
    localparam int VAL_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (IDX_W > CNT_W) ? IDX_W : CNT_W;

    // action codes
    typedef logic [2:0] action_t;
    localparam action_t ACT_READ     = 3'd0;
    localparam action_t ACT_INS_HEAD = 3'd1;
    localparam action_t ACT_INS_TAIL = 3'd2;
    localparam action_t ACT_INS_AT   = 3'd3;
    localparam action_t ACT_DELETE   = 3'd4;

    // status codes
    typedef logic [1:0] status_t;
    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_RANGE = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    // request transfer
    typedef struct packed {
        action_t                  action;
        logic [IDX_W-1:0]         index;
        logic signed [VAL_W-1:0]  value;
    } ils_req_t;

    // response transfer
    typedef struct packed {
        logic signed [VAL_W-1:0]  read_value;
        logic                     found;
        status_t                  status;
        logic [LEN_W-1:0]         length;
    } ils_rsp_t;

    // command broadcast along the cell chain
    typedef struct packed {
        logic                     ins;
        logic                     del;
        logic [CMP_W-1:0]         pos;
        logic [CMP_W-1:0]         rd_pos;
        logic [VAL_W-1:0]         value;
    } ils_cmd_t;

endpackage

@@ rtl/ils_cell.sv @@
// ----------------------------------------------------------------------------
// ils_cell
// One list slot: holds a value and shifts with its neighbours on insert
// and delete.
// ----------------------------------------------------------------------------
module ils_cell
    import ils_pkg::*;
(
    input  logic             clk,
    input  ils_cmd_t         cmd,
    input  logic [CMP_W-1:0] slot,
    input  logic [VAL_W-1:0] left,
    input  logic [VAL_W-1:0] right,
    output logic [VAL_W-1:0] held,
    output logic [VAL_W-1:0] rd_tap
);

    logic [VAL_W-1:0] value_reg;
    logic [VAL_W-1:0] value_next;
    logic             at_pos;
    logic             past_pos;

    assign at_pos   = (slot == cmd.pos);
    assign past_pos = (slot > cmd.pos);

    // next slot content
    always_comb
    begin
        value_next = value_reg;
        if (cmd.ins)
        begin
            if (at_pos)
                value_next = cmd.value;
            else if (past_pos)
                value_next = left;
        end
        else if (cmd.del)
        begin
            if (at_pos || past_pos)
                value_next = right;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign held   = value_reg;
    assign rd_tap = (slot == cmd.rd_pos) ? value_reg : '0;

endmodule

@@ rtl/ils_ctrl.sv @@
// ----------------------------------------------------------------------------
// ils_ctrl
// Decodes a request against the current length into a chain command,
// status and new length.
// ----------------------------------------------------------------------------
module ils_ctrl
    import ils_pkg::*;
(
    input  ils_req_t         req,
    input  logic             take,
    input  logic [CNT_W-1:0] count,
    output ils_cmd_t         cmd,
    output logic             found,
    output status_t          status,
    output logic [CNT_W-1:0] count_next
);

    logic [CMP_W-1:0] idx_x;
    logic [CMP_W-1:0] cnt_x;
    logic             full;
    logic             ins;
    logic             del;
    logic [CMP_W-1:0] pos;

    assign idx_x = CMP_W'(req.index);
    assign cnt_x = CMP_W'(count);
    assign full  = (cnt_x >= CMP_W'(CAPACITY));

    // operation decode
    always_comb
    begin
        ins    = 1'b0;
        del    = 1'b0;
        pos    = idx_x;
        found  = 1'b0;
        status = ST_DONE;
        case (req.action)
            ACT_READ:
            begin
                if (idx_x < cnt_x)
                    found = 1'b1;
                else
                    status = ST_RANGE;
            end
            ACT_INS_HEAD:
            begin
                pos = '0;
                if (full)
                    status = ST_FULL;
                else
                    ins = 1'b1;
            end
            ACT_INS_TAIL:
            begin
                pos = cnt_x;
                if (full)
                    status = ST_FULL;
                else
                    ins = 1'b1;
            end
            ACT_INS_AT:
            begin
                if (idx_x > cnt_x)
                    status = ST_RANGE;
                else if (full)
                    status = ST_FULL;
                else
                    ins = 1'b1;
            end
            ACT_DELETE:
            begin
                if (idx_x >= cnt_x)
                    status = ST_RANGE;
                else
                    del = 1'b1;
            end
            default:
            begin
                status = ST_DONE;
            end
        endcase
    end

    // length update
    always_comb
    begin
        count_next = count;
        if (ins)
            count_next = count + CNT_W'(1);
        else if (del)
            count_next = count - CNT_W'(1);
    end

    assign cmd.ins    = ins && take;
    assign cmd.del    = del && take;
    assign cmd.pos    = pos;
    assign cmd.rd_pos = idx_x;
    assign cmd.value  = req.value;

endmodule

@@ rtl/indexed_list_store_top.sv @@
// ----------------------------------------------------------------------------
// indexed_list_store_top
// Ordered list of signed words with indexed read, insert and delete.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req / req_valid / req_stall; each carries an action,
//   an index and a value. Every request gives exactly one response on
//   rsp / rsp_valid / rsp_stall with the read value, found flag, status and
//   the length after the operation.
//   The list is a row of CAPACITY cells; on an insert every cell past the
//   position takes its left neighbour, on a delete every cell at or past
//   the position its right neighbour, all in the same cycle, so one request
//   completes per cycle while rsp_stall is low. Each response is registered
//   in the output register before it is offered on rsp / rsp_valid.
//   A read selects the addressed cell through a masked OR across the row.
//   When the receiver stalls, the response is held in the output register
//   and a new request is taken only in the cycle that register drains.
//   Reset empties the list (length zero) and clears the response valid;
//   cell contents are not cleared and are only read below the length.
// ----------------------------------------------------------------------------
module indexed_list_store_top
    import ils_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  ils_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output ils_rsp_t rsp
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    ils_rsp_t         rsp_reg;
    ils_rsp_t         rsp_next;

    logic             take;
    ils_cmd_t         cmd;
    logic             found;
    status_t          status;
    logic [CNT_W-1:0] count_upd;

    logic [VAL_W-1:0] held   [CAPACITY];
    logic [VAL_W-1:0] rd_tap [CAPACITY];
    logic [VAL_W-1:0] rd_or;

    // request is taken when the output register is free or draining
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign take      = req_valid && !req_stall;

    // request decode
    ils_ctrl u_ctrl (
        .req        (req),
        .take       (take),
        .count      (count_reg),
        .cmd        (cmd),
        .found      (found),
        .status     (status),
        .count_next (count_upd)
    );

    // row of list cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [VAL_W-1:0] left_val;
        logic [VAL_W-1:0] right_val;

        if (i == 0)
        begin : g_head
            assign left_val = '0;
        end
        else
        begin : g_body
            assign left_val = held[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_val = held[i];
        end
        else
        begin : g_inner
            assign right_val = held[i+1];
        end

        ils_cell u_cell (
            .clk    (clk),
            .cmd    (cmd),
            .slot   (CMP_W'(i)),
            .left   (left_val),
            .right  (right_val),
            .held   (held[i]),
            .rd_tap (rd_tap[i])
        );
    end

    // read select across the row
    always_comb
    begin
        rd_or = '0;
        for (int i = 0; i < CAPACITY; i++)
            rd_or = rd_or | rd_tap[i];
    end

    // length and response next values
    always_comb
    begin
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        if (take)
        begin
            count_next          = count_upd;
            rsp_valid_next      = 1'b1;
            rsp_next.read_value = found ? rd_or : '0;
            rsp_next.found      = found;
            rsp_next.status     = status;
            rsp_next.length     = LEN_W'(count_upd);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    // length never passes the store depth
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("list length above capacity");

    // length moves only with an accepted transfer
    a_len_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(count_reg))
        else $error("list length changed without a transfer");

    // a granted insert grows the list by one
    a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the list");

    // a read hit always reports done
    a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.found |-> rsp.status == ST_DONE)
        else $error("read hit with non-done status");
`endif

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the indexed list store. A fixed table of operations
// covers the empty list, the value extremes, out-of-range positions and the
// unused action codes. Random operations then fill the store to capacity and
// drain it again several times. Every response is compared with a shadow copy
// of the list kept inside the bench, under random idling on both sides and two
// long receiver hold-offs that back the block up.
// ----------------------------------------------------------------------------
module tb;
    import ils_pkg::*;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int RANDOM_ITEMS = 850;
    localparam int HOLD_CYCLES  = 48;
    localparam int IDX_MAX      = (1 << IDX_W) - 1;

    // action codes the block does nothing with
    localparam action_t ACT_SPARE_FIRST = 3'd5;
    localparam action_t ACT_SPARE_MID   = 3'd6;
    localparam action_t ACT_SPARE_LAST  = 3'd7;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fffffff;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh80000000;
    localparam logic signed [VAL_W-1:0] VAL_NEG = 32'shffffffff;

    // table rows either carry their response or take it from the shadow list
    localparam logic     FIXED     = 1'b1;
    localparam logic     PREDICTED = 1'b0;
    localparam ils_rsp_t NO_RSP    = '0;

    typedef struct packed {
        ils_req_t op;
        logic     has_want;
        ils_rsp_t want;
    } list_case_t;

    localparam int N_CASES = 25;
    localparam list_case_t LIST_CASES [N_CASES] = '{
        // empty list: read, delete and insert past the end all miss
        {ACT_READ,     7'd0,   32'sd0,        FIXED, 32'sd0, 1'b0, ST_RANGE, 7'd0},
        {ACT_DELETE,   7'd0,   32'sd0,        FIXED, 32'sd0, 1'b0, ST_RANGE, 7'd0},
        {ACT_INS_AT,   7'd1,   32'sd5,        FIXED, 32'sd0, 1'b0, ST_RANGE, 7'd0},
        // insert at the length appends, then head and tail inserts
        {ACT_INS_AT,   7'd0,   VAL_MAX,       FIXED, 32'sd0, 1'b0, ST_DONE,  7'd1},
        {ACT_INS_HEAD, 7'd0,   VAL_MIN,       FIXED, 32'sd0, 1'b0, ST_DONE,  7'd2},
        {ACT_INS_TAIL, 7'h7f,  32'sd0,        FIXED, 32'sd0, 1'b0, ST_DONE,  7'd3},
        // read back every entry and just past the end
        {ACT_READ,     7'd0,   32'sd0,        FIXED, VAL_MIN, 1'b1, ST_DONE, 7'd3},
        {ACT_READ,     7'd1,   32'sd0,        FIXED, VAL_MAX, 1'b1, ST_DONE, 7'd3},
        {ACT_READ,     7'd2,   VAL_NEG,       FIXED, 32'sd0, 1'b1, ST_DONE,  7'd3},
        {ACT_READ,     7'd3,   32'sd0,        FIXED, 32'sd0, 1'b0, ST_RANGE, 7'd3},
        {ACT_READ,     7'h7f,  32'sd0,        FIXED, 32'sd0, 1'b0, ST_RANGE, 7'd3},
        // insert in the middle and append by position
        {ACT_INS_AT,   7'd1,   32'sh5a5a5a5a, PREDICTED, NO_RSP},
        {ACT_INS_AT,   7'd4,   VAL_NEG,       PREDICTED, NO_RSP},
        {ACT_INS_AT,   7'd64,  32'sd1,        FIXED, 32'sd0, 1'b0, ST_RANGE, 7'd5},
        {ACT_INS_AT,   7'h7f,  32'sd1,        FIXED, 32'sd0, 1'b0, ST_RANGE, 7'd5},
        {ACT_READ,     7'd4,   32'sd0,        PREDICTED, NO_RSP},
        // delete in the middle, out of range and at the head
        {ACT_DELETE,   7'd2,   32'sd0,        PREDICTED, NO_RSP},
        {ACT_DELETE,   7'h7f,  32'sd0,        FIXED, 32'sd0, 1'b0, ST_RANGE, 7'd4},
        {ACT_DELETE,   7'd0,   32'sd0,        PREDICTED, NO_RSP},
        {ACT_READ,     7'd0,   32'sd0,        PREDICTED, NO_RSP},
        // unused codes leave the list alone
        {ACT_SPARE_FIRST, 7'h55, 32'sh55555555, FIXED, 32'sd0, 1'b0, ST_DONE, 7'd3},
        {ACT_SPARE_MID,   7'h2a, 32'sh2aaaaaaa, FIXED, 32'sd0, 1'b0, ST_DONE, 7'd3},
        {ACT_SPARE_LAST,  7'h7f, VAL_NEG,       FIXED, 32'sd0, 1'b0, ST_DONE, 7'd3},
        // remove the tail and read what is left
        {ACT_DELETE,   7'd2,   32'sd0,        PREDICTED, NO_RSP},
        {ACT_READ,     7'd1,   32'sd0,        PREDICTED, NO_RSP}
    };

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    ils_req_t req       = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    ils_rsp_t rsp;

    // shadow copy of the list
    logic signed [VAL_W-1:0] shadow_list [CAPACITY];
    int                      shadow_len = 0;

    ils_rsp_t pending_rsp [$];
    int       fail_count    = 0;
    int       cycle_count   = 0;
    int       send_idle_pct = 13;
    int       recv_idle_pct = 74;
    int       hold_asked    = 0;
    int       hold_taken    = 0;
    int       hold_left     = 0;
    bit       growing       = 1'b1;

    indexed_list_store_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #6 clk = ~clk;

    // apply one operation to the shadow list and return its response
    function automatic ils_rsp_t apply_list_op(input ils_req_t op);
        ils_rsp_t res;
        int       pos;
        bit       full;
        res  = '0;
        pos  = op.index;
        full = (shadow_len >= CAPACITY);
        case (op.action)
            ACT_READ:
                if (pos < shadow_len)
                begin
                    res.read_value = shadow_list[pos];
                    res.found      = 1'b1;
                end
                else
                    res.status = ST_RANGE;
            ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_AT:
            begin
                if (op.action == ACT_INS_HEAD)
                    pos = 0;
                else if (op.action == ACT_INS_TAIL)
                    pos = shadow_len;
                // range is tested before fullness
                if (pos > shadow_len)
                    res.status = ST_RANGE;
                else if (full)
                    res.status = ST_FULL;
                else
                begin
                    for (int i = shadow_len; i > pos; i--)
                        shadow_list[i] = shadow_list[i - 1];
                    shadow_list[pos] = op.value;
                    shadow_len++;
                end
            end
            ACT_DELETE:
                if (pos >= shadow_len)
                    res.status = ST_RANGE;
                else
                begin
                    for (int i = pos; i + 1 < shadow_len; i++)
                        shadow_list[i] = shadow_list[i + 1];
                    shadow_len--;
                end
            default: ;
        endcase
        res.length = LEN_W'(shadow_len);
        return res;
    endfunction

    // random operation, biased towards filling or draining the list
    function automatic ils_req_t pick_list_op();
        ils_req_t op;
        int       roll;
        int       top;
        roll = $urandom_range(99);
        if (growing)
        begin
            if (roll < 25)      op.action = ACT_INS_AT;
            else if (roll < 45) op.action = ACT_INS_TAIL;
            else if (roll < 60) op.action = ACT_INS_HEAD;
            else if (roll < 82) op.action = ACT_READ;
            else if (roll < 90) op.action = ACT_DELETE;
            else if (roll < 94) op.action = action_t'($urandom_range(ACT_SPARE_LAST,
                                                                     ACT_SPARE_FIRST));
            else                op.action = ACT_INS_AT;
        end
        else
        begin
            if (roll < 45)      op.action = ACT_DELETE;
            else if (roll < 70) op.action = ACT_READ;
            else if (roll < 75) op.action = ACT_INS_HEAD;
            else if (roll < 80) op.action = ACT_INS_TAIL;
            else if (roll < 85) op.action = ACT_INS_AT;
            else if (roll < 90) op.action = action_t'($urandom_range(ACT_SPARE_LAST,
                                                                     ACT_SPARE_FIRST));
            else                op.action = ACT_DELETE;
        end

        // mostly a live position, sometimes past the end, rarely anything at all
        roll = $urandom_range(99);
        top  = (op.action == ACT_INS_AT) ? shadow_len : shadow_len - 1;
        if (roll < 80 && top >= 0)
            op.index = IDX_W'($urandom_range(top));
        else if (roll < 95)
            op.index = IDX_W'($urandom_range(CAPACITY, shadow_len));
        else
            op.index = IDX_W'($urandom_range(IDX_MAX));

        roll = $urandom_range(15);
        if (roll == 0)
            op.value = VAL_MAX;
        else if (roll == 1)
            op.value = VAL_MIN;
        else
            op.value = $urandom;
        return op;
    endfunction

    // offer one request, wait for the transfer, record its response
    task automatic send_op(input ils_req_t op, input logic has_want, input ils_rsp_t want);
        ils_rsp_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= op;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = apply_list_op(op);
        pending_rsp.push_back(has_want ? want : predicted);
    endtask

    // response side: check transfers, random stalls and the long hold-off
    always @(posedge clk)
    begin : response_side
        ils_rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("response with nothing outstanding: %p", rsp);
                fail_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.read_value !== want.read_value)
                begin
                    $error("read_value: expected %0d, got %0d", want.read_value,
                           rsp.read_value);
                    fail_count++;
                end
                if (rsp.found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, rsp.found);
                    fail_count++;
                end
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    fail_count++;
                end
                if (rsp.length !== want.length)
                begin
                    $error("length: expected %0d, got %0d", want.length, rsp.length);
                    fail_count++;
                end
            end
        end

        if (hold_taken != hold_asked)
        begin
            hold_taken = hold_asked;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left--;
        end
        else
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("indexed_list_store_top verification failed");
            $finish;
        end
    end

    // stimulus
    initial
    begin : stimulus
        int edge_hits;
        edge_hits = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int k = 0; k < N_CASES; k++)
            send_op(LIST_CASES[k].op, LIST_CASES[k].has_want, LIST_CASES[k].want);

        // random part: repeated fill to capacity and drain to empty
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 74;
                recv_idle_pct = 13;
            end
            if (k == 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_asked++;
            end
            if (k == RANDOM_ITEMS / 6)
                hold_asked++;

            // stay a few items at full or empty before turning round
            if (shadow_len == (growing ? CAPACITY : 0))
                edge_hits++;
            if (edge_hits >= 4)
            begin
                growing   = !growing;
                edge_hits = 0;
            end
            send_op(pick_list_op(), PREDICTED, NO_RSP);
        end
        req_valid <= 1'b0;

        // drain outstanding responses, then let the bench idle before reporting
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (fail_count == 0)
            $display("indexed_list_store_top verification clean");
        else
            $display("indexed_list_store_top verification failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/ils_pkg.sv
rtl/ils_cell.sv
rtl/ils_ctrl.sv
rtl/indexed_list_store_top.sv
tb/sv/tb.sv
